/* src/bfa_pkg.sv */
`default_nettype none

package bfa_pkg;

	localparam int NORMAL_WORDS = 8192;
	localparam int HUGE_WORDS = 8;

	localparam int NW_AW = (NORMAL_WORDS > 1) ? $clog2(NORMAL_WORDS) : 1;
	localparam int HW_AW = (HUGE_WORDS > 1) ? $clog2(HUGE_WORDS) : 1;
	localparam int SCAN_W = ((NW_AW > HW_AW) ? NW_AW : HW_AW) + 1;

	localparam int ADDR_W = 32;
	localparam int MAP_W = 32;
	localparam int BIT_W = 5;
	localparam int NORMAL_SHIFT = 12;
	localparam int HUGE_SHIFT = 22;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_NORMAL_BASE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_HUGE_BASE = 1'b1;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE = 1'b1;
	localparam logic POOL_NORMAL = 1'b0;
	localparam logic POOL_HUGE = 1'b1;

	typedef enum logic [2:0] {
		STAT_OK = 3'd0,
		STAT_EXHAUSTED = 3'd1,
		STAT_BOUNDS = 3'd2,
		STAT_MISALIGNED = 3'd3,
		STAT_FREE = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_A_RD,
		S_A_EVAL,
		S_A_ADDR,
		S_F_CHK,
		S_F_IDX,
		S_F_RD,
		S_F_EVAL,
		S_DONE
	} state_t;

	typedef struct packed {
		logic command;
		logic pool;
		logic [ADDR_W-1:0] free_address;
	} req_t;

	typedef struct packed {
		logic [ADDR_W-1:0] frame_address;
		status_t status;
	} resp_t;

	// Position of the lowest clear bit, found by halving the search window.
	function automatic logic [BIT_W-1:0] lowest_zero(input logic [MAP_W-1:0] v);
		logic [MAP_W-1:0] x;
		logic [BIT_W-1:0] pos;
		x = ~v;
		pos = '0;
		for (int i = BIT_W - 1; i >= 0; i--) begin
			if ((x & ((MAP_W'(1) << (1 << i)) - MAP_W'(1))) == '0) begin
				pos[i] = 1'b1;
				x = x >> (1 << i);
			end
		end
		return pos;
	endfunction

endpackage

`default_nettype wire

/* src/bfa_ram.sv */
`default_nettype none

module bfa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic clk,
	input  wire logic we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

/* src/bitmap_frame_allocator.sv */
// First-fit physical frame allocator over a 4 KiB frame bitmap and a 4 MiB frame bitmap.
// An item enters on in_valid/in_ready and carries a command: allocate from the chosen
// pool, or free the frame at free_address. Each item gives exactly one result item on
// out_valid/out_ready with the frame address (zero on free and on error) and a status.
// Bases are written through cfg_we/cfg_index/cfg_wdata; the user must write them only
// while the block is idle, which the block itself does not enforce. One item is worked
// on at a time; in_ready is high only when the sequencer is idle. An allocation reads
// bitmap words one by one, each with a RAM read in S_A_RD and an evaluation in S_A_EVAL.
// A pointer to the lowest word that may hold a clear bit keeps the 4 KiB scan to one
// word in the common case; the 4 MiB map is scanned from word zero (up to 8 words).
// A free passes S_F_CHK, S_F_IDX, S_F_RD and S_F_EVAL, and goes straight to S_DONE when
// an address check fails; the sequencer returns to S_IDLE after each result before it
// takes the next item. A finished result sits in an output register, so the next item
// is accepted while it waits; a stalled receiver holds only the item after that.
// Reset clears the bases and both maps at once: the 4 MiB map is in flip-flops, and
// 4 KiB map words above a high-water mark read as zero, so no clearing pass is needed.
`default_nettype none

module bitmap_frame_allocator import bfa_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_ready,
	input  wire req_t in_item,
	output logic out_valid,
	input  wire logic out_ready,
	output resp_t out_item,
	input  wire logic cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [ADDR_W-1:0] cfg_wdata
);

	state_t state_q, state_d;

	logic [ADDR_W-1:0] normal_base_q, huge_base_q;
	logic [ADDR_W-1:0] addr_q;
	logic sel_huge_q;
	logic [SCAN_W-1:0] ptr_q;
	logic [BIT_W-1:0] bit_q;
	logic zero_q;
	logic [NW_AW:0] hint_q, hwm_q;
	logic [MAP_W-1:0] huge_map_q [HUGE_WORDS];
	logic [MAP_W-1:0] huge_rd_q;
	logic [ADDR_W-1:0] res_addr_q;
	status_t res_status_q;
	logic out_valid_q;
	resp_t out_item_q;

	logic [MAP_W-1:0] ram_rdata, cur_word, set_word, clr_word, wr_data;
	logic word_full, bit_set, scan_end;
	logic [BIT_W-1:0] free_bit;
	logic [SCAN_W-1:0] words_lim;
	logic below, is_huge, misalign, out_of_map;
	logic [ADDR_W-1:0] sel_base, diff, fidx, fword, offset, alloc_addr;
	logic [NW_AW:0] ptr_n, ptr_n1;
	logic ram_we, hm_we, out_load;

	bfa_ram #(
		.WIDTH(MAP_W),
		.DEPTH(NORMAL_WORDS)
	) u_normal_map (
		.clk(clk),
		.we(ram_we),
		.waddr(ptr_q[NW_AW-1:0]),
		.wdata(wr_data),
		.raddr(ptr_q[NW_AW-1:0]),
		.rdata(ram_rdata)
	);

	assign cur_word = zero_q ? '0 : (sel_huge_q ? huge_rd_q : ram_rdata);
	assign word_full = &cur_word;
	assign free_bit = lowest_zero(cur_word);
	assign set_word = cur_word | (MAP_W'(1) << free_bit);
	assign clr_word = cur_word & ~(MAP_W'(1) << bit_q);
	assign bit_set = cur_word[bit_q];
	assign words_lim = sel_huge_q ? SCAN_W'(HUGE_WORDS) : SCAN_W'(NORMAL_WORDS);
	assign scan_end = ptr_q >= words_lim;
	assign ptr_n = (NW_AW + 1)'(ptr_q);
	assign ptr_n1 = ptr_n + 1'b1;

	assign below = addr_q < normal_base_q;
	assign is_huge = addr_q >= huge_base_q;
	assign sel_base = sel_huge_q ? huge_base_q : normal_base_q;
	assign misalign = sel_huge_q ? (addr_q[HUGE_SHIFT-1:0] != '0)
		: (addr_q[NORMAL_SHIFT-1:0] != '0);
	assign diff = addr_q - sel_base;
	assign fidx = sel_huge_q ? (diff >> HUGE_SHIFT) : (diff >> NORMAL_SHIFT);
	assign fword = fidx >> BIT_W;
	assign out_of_map = fword >= (sel_huge_q ? ADDR_W'(HUGE_WORDS) : ADDR_W'(NORMAL_WORDS));

	assign offset = sel_huge_q
		? ((ADDR_W'(ptr_q) << (HUGE_SHIFT + BIT_W)) | (ADDR_W'(bit_q) << HUGE_SHIFT))
		: ((ADDR_W'(ptr_q) << (NORMAL_SHIFT + BIT_W)) | (ADDR_W'(bit_q) << NORMAL_SHIFT));
	assign alloc_addr = sel_base + offset;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = (in_item.command == CMD_ALLOC) ? S_A_RD : S_F_CHK;
				end
			end
			S_A_RD: state_d = scan_end ? S_DONE : S_A_EVAL;
			S_A_EVAL: state_d = word_full ? S_A_RD : S_A_ADDR;
			S_A_ADDR: state_d = S_DONE;
			S_F_CHK: state_d = below ? S_DONE : S_F_IDX;
			S_F_IDX: state_d = (misalign || out_of_map) ? S_DONE : S_F_RD;
			S_F_RD: state_d = S_F_EVAL;
			S_F_EVAL: state_d = S_DONE;
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		ram_we = 1'b0;
		hm_we = 1'b0;
		out_load = 1'b0;
		wr_data = clr_word;
		case (state_q)
			S_IDLE: in_ready = 1'b1;
			S_A_EVAL: begin
				wr_data = set_word;
				ram_we = !word_full && !sel_huge_q;
				hm_we = !word_full && sel_huge_q;
			end
			S_F_EVAL: begin
				ram_we = bit_set && !sel_huge_q;
				hm_we = bit_set && sel_huge_q;
			end
			S_DONE: out_load = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			normal_base_q <= '0;
			huge_base_q <= '0;
			hint_q <= '0;
			hwm_q <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < HUGE_WORDS; i++) begin
				huge_map_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					REG_NORMAL_BASE: normal_base_q <= cfg_wdata;
					REG_HUGE_BASE: huge_base_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (hm_we) begin
				huge_map_q[ptr_q[HW_AW-1:0]] <= wr_data;
			end
			if (state_q == S_A_EVAL && !word_full && !sel_huge_q) begin
				hint_q <= (&set_word) ? ptr_n1 : ptr_n;
				if (ptr_n1 > hwm_q) begin
					hwm_q <= ptr_n1;
				end
			end
			if (state_q == S_F_EVAL && bit_set && !sel_huge_q && ptr_n < hint_q) begin
				hint_q <= ptr_n;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		huge_rd_q <= huge_map_q[ptr_q[HW_AW-1:0]];
		zero_q <= !sel_huge_q && (ptr_q >= SCAN_W'(hwm_q));
		if (out_load) begin
			out_item_q.frame_address <= res_addr_q;
			out_item_q.status <= res_status_q;
		end
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					addr_q <= in_item.free_address;
					sel_huge_q <= (in_item.pool == POOL_HUGE);
					ptr_q <= (in_item.pool == POOL_HUGE) ? '0 : SCAN_W'(hint_q);
					res_addr_q <= '0;
					res_status_q <= STAT_OK;
				end
			end
			S_A_RD: begin
				if (scan_end) begin
					res_status_q <= STAT_EXHAUSTED;
				end
			end
			S_A_EVAL: begin
				if (word_full) begin
					ptr_q <= ptr_q + 1'b1;
				end else begin
					bit_q <= free_bit;
				end
			end
			S_A_ADDR: res_addr_q <= alloc_addr;
			S_F_CHK: begin
				sel_huge_q <= is_huge;
				if (below) begin
					res_status_q <= STAT_BOUNDS;
				end
			end
			S_F_IDX: begin
				if (misalign) begin
					res_status_q <= STAT_MISALIGNED;
				end else if (out_of_map) begin
					res_status_q <= STAT_BOUNDS;
				end
				ptr_q <= SCAN_W'(fword);
				bit_q <= fidx[BIT_W-1:0];
			end
			S_F_EVAL: begin
				if (!bit_set) begin
					res_status_q <= STAT_FREE;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_item = out_item_q;

`ifndef SYNTH
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input accepted while an item is in flight");

	a_hint_below_hwm: assert property (@(posedge clk) disable iff (!arst_n)
		(hint_q <= hwm_q) && (hwm_q <= (NW_AW + 1)'(NORMAL_WORDS)))
		else $error("search pointer beyond high-water mark");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == S_DONE))
		else $error("result raised outside the completion state");

	a_error_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_item.status != STAT_OK) |-> (out_item.frame_address == '0))
		else $error("error result carries a frame address");
`endif

endmodule

`default_nettype wire

/* sim/bfa_checker.sv */
module bfa_checker import bfa_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input req_t in_item,
	input logic out_valid,
	input logic out_ready,
	input resp_t out_item,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [ADDR_W-1:0] cfg_wdata,
	output int fail_count,
	output int pending
);

	logic [MAP_W-1:0] normal_used [NORMAL_WORDS];
	logic [MAP_W-1:0] huge_used [HUGE_WORDS];
	logic [ADDR_W-1:0] normal_origin;
	logic [ADDR_W-1:0] huge_origin;
	int normal_hint;
	resp_t frame_q [$];
	resp_t want;

	// Every word below normal_hint is known to be full, so the 4 KiB scan starts there.
	function automatic resp_t next_frame(input req_t req);
		resp_t res;
		logic [ADDR_W-1:0] slot;
		logic found;
		int w;
		int b;
		res.frame_address = '0;
		res.status = STAT_OK;
		found = 1'b0;
		if (req.command == CMD_ALLOC) begin
			if (req.pool == POOL_NORMAL) begin
				for (w = normal_hint; w < NORMAL_WORDS && !found; w++) begin
					for (b = 0; b < MAP_W && !found; b++) begin
						if (!normal_used[w][b]) begin
							normal_used[w][b] = 1'b1;
							normal_hint = w;
							slot = ADDR_W'(w * MAP_W + b);
							res.frame_address = normal_origin + (slot << NORMAL_SHIFT);
							found = 1'b1;
						end
					end
				end
			end else begin
				for (w = 0; w < HUGE_WORDS && !found; w++) begin
					for (b = 0; b < MAP_W && !found; b++) begin
						if (!huge_used[w][b]) begin
							huge_used[w][b] = 1'b1;
							slot = ADDR_W'(w * MAP_W + b);
							res.frame_address = huge_origin + (slot << HUGE_SHIFT);
							found = 1'b1;
						end
					end
				end
			end
			if (!found) begin
				res.status = STAT_EXHAUSTED;
			end
		end else if (req.free_address < normal_origin) begin
			res.status = STAT_BOUNDS;
		end else if (req.free_address >= huge_origin) begin
			if (req.free_address[HUGE_SHIFT-1:0] != '0) begin
				res.status = STAT_MISALIGNED;
			end else begin
				slot = (req.free_address - huge_origin) >> HUGE_SHIFT;
				if ((slot >> BIT_W) >= ADDR_W'(HUGE_WORDS)) begin
					res.status = STAT_BOUNDS;
				end else begin
					w = int'(slot >> BIT_W);
					b = int'(slot[BIT_W-1:0]);
					if (!huge_used[w][b])
						res.status = STAT_FREE;
					else
						huge_used[w][b] = 1'b0;
				end
			end
		end else begin
			if (req.free_address[NORMAL_SHIFT-1:0] != '0) begin
				res.status = STAT_MISALIGNED;
			end else begin
				slot = (req.free_address - normal_origin) >> NORMAL_SHIFT;
				if ((slot >> BIT_W) >= ADDR_W'(NORMAL_WORDS)) begin
					res.status = STAT_BOUNDS;
				end else begin
					w = int'(slot >> BIT_W);
					b = int'(slot[BIT_W-1:0]);
					if (!normal_used[w][b]) begin
						res.status = STAT_FREE;
					end else begin
						normal_used[w][b] = 1'b0;
						if (w < normal_hint)
							normal_hint = w;
					end
				end
			end
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NORMAL_WORDS; i++)
				normal_used[i] = '0;
			for (int i = 0; i < HUGE_WORDS; i++)
				huge_used[i] = '0;
			normal_origin = '0;
			huge_origin = '0;
			normal_hint = 0;
			frame_q.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_NORMAL_BASE: normal_origin = cfg_wdata;
					REG_HUGE_BASE: huge_origin = cfg_wdata;
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				frame_q.push_back(next_frame(in_item));
			if (out_valid && out_ready) begin
				if (frame_q.size() == 0) begin
					$error("result item with nothing expected: frame_address %h, status %0d",
						out_item.frame_address, out_item.status);
					fail_count++;
				end else begin
					want = frame_q.pop_front();
					if (out_item.frame_address !== want.frame_address) begin
						$error("frame_address: expected %h, got %h",
							want.frame_address, out_item.frame_address);
						fail_count++;
					end
					if (out_item.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, out_item.status);
						fail_count++;
					end
				end
			end
			pending = frame_q.size();
		end
	end

endmodule

/* sim/bitmap_frame_allocator_tb.sv */
module bitmap_frame_allocator_tb;
	import bfa_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		logic pool;
		logic [ADDR_W-1:0] addr;
	} held_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	req_t in_item;
	logic out_valid;
	logic out_ready;
	resp_t out_item;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [ADDR_W-1:0] cfg_wdata;
	int fail_count;
	int pending;

	int sent_count;
	int done_count;
	int cycle_count;
	int setting_count;
	int status_tally [8];
	logic sender_quiet;
	logic ready_quiet;
	logic held_off;
	logic [ADDR_W-1:0] normal_cur;
	logic [ADDR_W-1:0] huge_cur;
	held_t live_q [$];
	logic [ADDR_W-1:0] retired_q [$];
	req_t inflight_q [$];
	req_t origin;

	bitmap_frame_allocator u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	bfa_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.fail_count(fail_count),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int pick_gap(input logic quiet);
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	task automatic send_item(input logic cmd, input logic pl, input logic [ADDR_W-1:0] addr);
		int gap;
		req_t req;
		req.command = cmd;
		req.pool = pl;
		req.free_address = addr;
		gap = pick_gap(sender_quiet);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_item <= req;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		inflight_q.push_back(req);
		sent_count++;
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (done_count < sent_count) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_bases(input logic [ADDR_W-1:0] nb, input logic [ADDR_W-1:0] hb);
		wait_idle();
		write_reg(REG_NORMAL_BASE, nb);
		write_reg(REG_HUGE_BASE, hb);
		normal_cur = nb;
		huge_cur = hb;
		setting_count++;
	endtask

	task automatic drain_live();
		held_t h;
		wait_idle();
		while (live_q.size() > 0) begin
			h = live_q.pop_front();
			send_item(CMD_FREE, 1'($urandom_range(0, 1)), h.addr);
		end
		wait_idle();
		retired_q.delete();
	endtask

	// Mostly allocations and frees of frames that are really held, plus a share of
	// bad addresses: random, misaligned, below the base, past either map, freed twice.
	task automatic next_request(output logic cmd, output logic pl,
		output logic [ADDR_W-1:0] addr);
		int pick;
		int at;
		held_t h;
		cmd = CMD_FREE;
		pl = 1'($urandom_range(0, 1));
		addr = $urandom;
		pick = $urandom_range(0, 99);
		if (pick < 45 || (pick < 75 && live_q.size() == 0)) begin
			cmd = CMD_ALLOC;
			pl = ($urandom_range(0, 99) < 25) ? POOL_HUGE : POOL_NORMAL;
		end else if (pick < 75) begin
			at = $urandom_range(0, live_q.size() - 1);
			h = live_q[at];
			live_q.delete(at);
			retired_q.push_back(h.addr);
			addr = h.addr;
		end else begin
			case ($urandom_range(0, 5))
				0: ;
				1: begin
					if (live_q.size() > 0) begin
						h = live_q[$urandom_range(0, live_q.size() - 1)];
						if (h.pool == POOL_HUGE)
							addr = h.addr + $urandom_range(1, 32'h003F_FFFF);
						else
							addr = h.addr + $urandom_range(1, 32'h0000_0FFF);
					end
				end
				2: begin
					if (normal_cur != '0)
						addr = $urandom_range(0, normal_cur - 1);
				end
				3: addr = normal_cur + 32'h4000_0000
					+ (ADDR_W'($urandom_range(0, 255)) << NORMAL_SHIFT);
				4: addr = huge_cur + 32'h4000_0000
					+ (ADDR_W'($urandom_range(0, 63)) << HUGE_SHIFT);
				default: begin
					if (retired_q.size() > 0)
						addr = retired_q[$urandom_range(0, retired_q.size() - 1)];
				end
			endcase
		end
	endtask

	task automatic run_phase(input logic [ADDR_W-1:0] nb, input logic [ADDR_W-1:0] hb,
		input int fill, input int count);
		logic cmd;
		logic pl;
		logic [ADDR_W-1:0] addr;
		set_bases(nb, hb);
		sender_quiet = ($urandom_range(0, 3) == 0);
		repeat (fill) send_item(CMD_ALLOC, POOL_HUGE, '0);
		repeat (count) begin
			next_request(cmd, pl, addr);
			send_item(cmd, pl, addr);
		end
		drain_live();
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("bitmap_frame_allocator: mismatch");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			done_count++;
			status_tally[int'(out_item.status)]++;
			if (inflight_q.size() > 0) begin
				origin = inflight_q.pop_front();
				if (origin.command == CMD_ALLOC && out_item.status == STAT_OK)
					live_q.push_back('{pool: origin.pool, addr: out_item.frame_address});
			end
		end
	end

	// The long hold lets the block finish one item, take the next and then stall its input.
	initial begin
		int stall;
		out_ready = 1'b0;
		ready_quiet = 1'b0;
		held_off = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (!held_off && done_count >= 80) begin
				held_off = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			if ($urandom_range(0, 39) == 0)
				ready_quiet = !ready_quiet;
			stall = pick_gap(ready_quiet);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(0, 15)) @(negedge clk);
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		cfg_we = 1'b0;
		cfg_index = REG_NORMAL_BASE;
		cfg_wdata = '0;
		sender_quiet = 1'b0;
		normal_cur = '0;
		huge_cur = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Both bases at zero: every free lands in the 4 MiB map.
		send_item(CMD_ALLOC, POOL_NORMAL, '0);
		send_item(CMD_ALLOC, POOL_HUGE, '0);
		send_item(CMD_FREE, POOL_NORMAL, 32'h0000_0000);
		send_item(CMD_FREE, POOL_HUGE, 32'h0000_0000);
		send_item(CMD_FREE, POOL_NORMAL, 32'h0000_1000);
		send_item(CMD_FREE, POOL_NORMAL, 32'hFFFF_FFFF);
		send_item(CMD_FREE, POOL_HUGE, 32'hFFC0_0000);

		set_bases(32'h0010_0000, 32'h8000_0000);
		send_item(CMD_ALLOC, POOL_NORMAL, '0);
		send_item(CMD_ALLOC, POOL_NORMAL, 32'hFFFF_FFFF);
		send_item(CMD_ALLOC, POOL_HUGE, '0);
		send_item(CMD_FREE, POOL_NORMAL, 32'h0000_0000);
		send_item(CMD_FREE, POOL_NORMAL, 32'h0010_0800);
		send_item(CMD_FREE, POOL_NORMAL, 32'h0010_1000);
		send_item(CMD_FREE, POOL_HUGE, 32'h0010_1000);
		send_item(CMD_FREE, POOL_NORMAL, 32'h4010_0000);
		send_item(CMD_FREE, POOL_NORMAL, 32'h8000_0000);
		send_item(CMD_FREE, POOL_HUGE, 32'h8000_0000);
		send_item(CMD_FREE, POOL_HUGE, 32'hC000_0000);
		send_item(CMD_FREE, POOL_HUGE, 32'hFFFF_FFFF);
		send_item(CMD_ALLOC, POOL_NORMAL, '0);
		drain_live();

		run_phase(32'h0000_0000, 32'h8000_0000, 0, 90);
		run_phase(32'h0010_0000, 32'h4000_0000, 264, 40);
		run_phase(32'hFFC0_0000, 32'hFFC0_0000, 0, 40);
		run_phase(32'h0000_0123, 32'h9000_0800, 0, 50);
		run_phase(32'h0040_0000, 32'h0000_0000, 0, 40);
		run_phase(32'h0000_0000, 32'hFFC0_0000, 0, 50);
		wait_idle();

		$display("Covered %0d items over %0d base settings,", sent_count, setting_count);
		$display("with a full 4 MiB map and a long output stall.");
		$display("Results: %0d ok, %0d exhausted, %0d out of bounds,",
			status_tally[STAT_OK], status_tally[STAT_EXHAUSTED], status_tally[STAT_BOUNDS]);
		$display("%0d misaligned, %0d already free.",
			status_tally[STAT_MISALIGNED], status_tally[STAT_FREE]);
		if (fail_count == 0 && pending == 0) begin
			$display("bitmap_frame_allocator: match");
		end else begin
			$display("bitmap_frame_allocator: mismatch");
		end
		$finish;
	end

endmodule
